[hw/rtl/rocs_pkg.sv]
// ----------------------------------------------------------------------------
// Region occupancy steering package
// Shared types, register codes and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rocs_pkg;

  localparam int CntW   = 20;
  localparam int PosW   = 10;
  localparam int RegW   = 10;
  localparam int AngW   = 7;
  localparam int ProdW  = CntW + RegW;
  localparam int RecipW = 31;
  localparam int QuotW  = 21;

  localparam logic [CntW-1:0]   CNT_MAX     = {CntW{1'b1}};
  localparam logic [PosW-1:0]   POS_MAX     = {PosW{1'b1}};
  // ceil(2**40 / 1000); floor(x * RECIP / 2**40) equals floor(x / 1000) for x < 2**30.
  localparam logic [RecipW-1:0] RECIP       = 31'd1099511628;
  localparam int                RecipShift  = 40;

  localparam int ApbAddrW = 5;

  localparam logic [2:0] REG_LEFT_WIDTH    = 3'd0;
  localparam logic [2:0] REG_CENTER_START  = 3'd1;
  localparam logic [2:0] REG_CENTER_WIDTH  = 3'd2;
  localparam logic [2:0] REG_RIGHT_START   = 3'd3;
  localparam logic [2:0] REG_RIGHT_WIDTH   = 3'd4;
  localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd5;
  localparam logic [2:0] REG_CENTER_BIAS   = 3'd6;
  localparam logic [2:0] REG_TURN_ANGLE    = 3'd7;

  localparam logic [1:0] REGION_LEFT   = 2'd0;
  localparam logic [1:0] REGION_CENTER = 2'd1;
  localparam logic [1:0] REGION_RIGHT  = 2'd2;

  typedef struct packed {
    logic [RegW-1:0] left_width;
    logic [RegW-1:0] center_start;
    logic [RegW-1:0] center_width;
    logic [RegW-1:0] right_start;
    logic [RegW-1:0] right_width;
    logic [RegW-1:0] window_height;
    logic [RegW-1:0] center_bias;
    logic [AngW-1:0] turn_angle;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic [CntW-1:0] left_cnt;
    logic [CntW-1:0] center_cnt;
    logic [CntW-1:0] right_cnt;
    logic            stopped;
  } snap_t;

endpackage

`default_nettype wire

[hw/rtl/region_occupancy_steering_top.sv]
// ----------------------------------------------------------------------------
// Region occupancy steering
// Counts occupied pixels in three column windows and steers toward the
// least occupied one at the end of each frame.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle without gaps, pixels and speed
// updates alike, as long as the result side keeps up. A pixel that ends a
// frame produces one result item that passes, in order, through the input
// register, the snapshot register of the select pipeline, the bias multiply,
// the reciprocal multiply that divides by 1000, and the final compare into the
// output register. The accumulator keeps counting a new frame while earlier
// results drain, so back-to-back short frames also run at one item per
// cycle while the result side keeps up.
`default_nettype none

module region_occupancy_steering_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rocs_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // blue [7:0], green [15:8], red [23:16], speed_value [39:24]
  input  wire logic [39:0]                   s_tdata,
  // op [0], end_of_line [1]
  input  wire logic [1:0]                    s_tuser,
  // end_of_frame
  input  wire logic                          s_tlast,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // steer_angle [7:0], chosen_region [9:8], left_total [29:10],
  // center_total [49:30], right_total [69:50], zero [71:70]
  output logic [71:0]                        m_tdata
);
  import rocs_pkg::*;

  cfg_t            cfg;
  snap_t           snap;
  logic            snap_ready;
  logic [7:0]      steer_angle;
  logic [1:0]      chosen_region;
  logic [CntW-1:0] left_total;
  logic [CntW-1:0] center_total;
  logic [CntW-1:0] right_total;

  rocs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rocs_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .op           (s_tuser[0]),
    .blue         (s_tdata[7:0]),
    .green        (s_tdata[15:8]),
    .red          (s_tdata[23:16]),
    .end_of_line  (s_tuser[1]),
    .end_of_frame (s_tlast),
    .speed_value  (s_tdata[39:24]),
    .snap         (snap),
    .snap_ready   (snap_ready)
  );

  rocs_select u_select (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .snap          (snap),
    .snap_ready    (snap_ready),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .steer_angle   (steer_angle),
    .chosen_region (chosen_region),
    .left_total    (left_total),
    .center_total  (center_total),
    .right_total   (right_total)
  );

  assign m_tdata = {2'b00, right_total, center_total, left_total, chosen_region, steer_angle};

endmodule

`default_nettype wire

[hw/rtl/rocs_cfg.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the window geometry, bias and angle.
// ----------------------------------------------------------------------------
`default_nettype none

module rocs_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rocs_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output rocs_pkg::cfg_t                     cfg
);
  import rocs_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[ApbAddrW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_width    <= 10'd213;
      cfg.center_start  <= 10'd213;
      cfg.center_width  <= 10'd214;
      cfg.right_start   <= 10'd417;
      cfg.right_width   <= 10'd213;
      cfg.window_height <= 10'd480;
      cfg.center_bias   <= 10'd900;
      cfg.turn_angle    <= 7'd10;
    end else if (wr_en) begin
      unique case (idx)
        REG_LEFT_WIDTH:    cfg.left_width    <= pwdata[RegW-1:0];
        REG_CENTER_START:  cfg.center_start  <= pwdata[RegW-1:0];
        REG_CENTER_WIDTH:  cfg.center_width  <= pwdata[RegW-1:0];
        REG_RIGHT_START:   cfg.right_start   <= pwdata[RegW-1:0];
        REG_RIGHT_WIDTH:   cfg.right_width   <= pwdata[RegW-1:0];
        REG_WINDOW_HEIGHT: cfg.window_height <= pwdata[RegW-1:0];
        REG_CENTER_BIAS:   cfg.center_bias   <= pwdata[RegW-1:0];
        REG_TURN_ANGLE:    cfg.turn_angle    <= pwdata[AngW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_LEFT_WIDTH:    prdata[RegW-1:0] = cfg.left_width;
      REG_CENTER_START:  prdata[RegW-1:0] = cfg.center_start;
      REG_CENTER_WIDTH:  prdata[RegW-1:0] = cfg.center_width;
      REG_RIGHT_START:   prdata[RegW-1:0] = cfg.right_start;
      REG_RIGHT_WIDTH:   prdata[RegW-1:0] = cfg.right_width;
      REG_WINDOW_HEIGHT: prdata[RegW-1:0] = cfg.window_height;
      REG_CENTER_BIAS:   prdata[RegW-1:0] = cfg.center_bias;
      REG_TURN_ANGLE:    prdata[AngW-1:0] = cfg.turn_angle;
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/rocs_accum.sv]
// ----------------------------------------------------------------------------
// Occupancy accumulator
// Input register, raster position tracking and saturating window counters.
// ----------------------------------------------------------------------------
`default_nettype none

module rocs_accum (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire rocs_pkg::cfg_t cfg,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           op,
  input  wire logic [7:0]     blue,
  input  wire logic [7:0]     green,
  input  wire logic [7:0]     red,
  input  wire logic           end_of_line,
  input  wire logic           end_of_frame,
  input  wire logic [15:0]    speed_value,
  output rocs_pkg::snap_t     snap,
  input  wire logic           snap_ready
);
  import rocs_pkg::*;

  logic            v0;
  logic            op0;
  logic [7:0]      blue0;
  logic [7:0]      green0;
  logic [7:0]      red0;
  logic            eol0;
  logic            eof0;
  logic [15:0]     spd0;

  logic [PosW-1:0] column_position;
  logic [PosW-1:0] row_position;
  logic [CntW-1:0] left_count;
  logic [CntW-1:0] center_count;
  logic [CntW-1:0] right_count;
  logic            stopped;

  logic [CntW-1:0] left_count_next;
  logic [CntW-1:0] center_count_next;
  logic [CntW-1:0] right_count_next;

  logic            is_result;
  logic            consume;
  logic            occupied;
  logic            in_left;
  logic            in_center;
  logic            in_right;

  assign is_result = v0 && !op0 && eof0;
  assign consume   = v0 && (!is_result || snap_ready);
  assign in_ready  = !v0 || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (in_ready) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op0    <= op;
      blue0  <= blue;
      green0 <= green;
      red0   <= red;
      eol0   <= end_of_line;
      eof0   <= end_of_frame;
      spd0   <= speed_value;
    end
  end

  always_comb begin
    occupied  = !((blue0 == 8'd0 || blue0 == 8'd255) && green0 == 8'd0 && red0 == 8'd0)
                && (row_position < cfg.window_height);
    in_left   = column_position < cfg.left_width;
    in_center = (column_position >= cfg.center_start) &&
                ({1'b0, column_position} < ({1'b0, cfg.center_start} +
                                            {1'b0, cfg.center_width}));
    in_right  = (column_position >= cfg.right_start) &&
                ({1'b0, column_position} < ({1'b0, cfg.right_start} +
                                            {1'b0, cfg.right_width}));

    left_count_next   = left_count;
    center_count_next = center_count;
    right_count_next  = right_count;
    if (occupied && in_left && left_count != CNT_MAX) begin
      left_count_next = left_count + 1'b1;
    end
    if (occupied && in_center && center_count != CNT_MAX) begin
      center_count_next = center_count + 1'b1;
    end
    if (occupied && in_right && right_count != CNT_MAX) begin
      right_count_next = right_count + 1'b1;
    end
  end

  always_comb begin
    snap.valid      = is_result;
    snap.left_cnt   = left_count_next;
    snap.center_cnt = center_count_next;
    snap.right_cnt  = right_count_next;
    snap.stopped    = stopped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      left_count      <= '0;
      center_count    <= '0;
      right_count     <= '0;
      stopped         <= 1'b1;
    end else if (consume) begin
      if (op0) begin
        stopped <= (spd0 == 16'd0);
      end else if (eof0) begin
        column_position <= '0;
        row_position    <= '0;
        left_count      <= '0;
        center_count    <= '0;
        right_count     <= '0;
      end else begin
        left_count   <= left_count_next;
        center_count <= center_count_next;
        right_count  <= right_count_next;
        if (eol0) begin
          column_position <= '0;
          if (row_position != POS_MAX) begin
            row_position <= row_position + 1'b1;
          end
        end else if (column_position != POS_MAX) begin
          column_position <= column_position + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rocs_select.sv]
// ----------------------------------------------------------------------------
// Region selection
// Scales the center count, picks the least occupied window and holds the
// result item in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rocs_select (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire rocs_pkg::cfg_t             cfg,
  input  wire rocs_pkg::snap_t            snap,
  output logic                            snap_ready,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [7:0]                      steer_angle,
  output logic [1:0]                      chosen_region,
  output logic [rocs_pkg::CntW-1:0]       left_total,
  output logic [rocs_pkg::CntW-1:0]       center_total,
  output logic [rocs_pkg::CntW-1:0]       right_total
);
  import rocs_pkg::*;

  logic                      v1, v2, v3;
  logic                      rdy1, rdy2, rdy3, rdy4;

  logic [CntW-1:0]           lt1, ct1, rt1;
  logic                      st1;
  logic [CntW-1:0]           lt2, rt2;
  logic [ProdW-1:0]          prod2;
  logic                      st2;
  logic [CntW-1:0]           lt3, rt3;
  logic [QuotW-1:0]          quot3;
  logic                      st3;

  logic [ProdW+RecipW-1:0]   recip_prod;
  logic [CntW-1:0]           ct_sat;
  logic [1:0]                region;
  logic [7:0]                angle;

  assign rdy4       = !out_valid || out_ready;
  assign rdy3       = !v3 || rdy4;
  assign rdy2       = !v2 || rdy3;
  assign rdy1       = !v1 || rdy2;
  assign snap_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= snap.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  assign recip_prod = prod2 * RECIP;

  always_comb begin
    ct_sat = (quot3 > {1'b0, CNT_MAX}) ? CNT_MAX : quot3[CntW-1:0];
    if (lt3 <= ct_sat && lt3 <= rt3) begin
      region = REGION_LEFT;
      angle  = 8'd0 - {1'b0, cfg.turn_angle};
    end else if (ct_sat <= rt3) begin
      region = REGION_CENTER;
      angle  = 8'd0;
    end else begin
      region = REGION_RIGHT;
      angle  = {1'b0, cfg.turn_angle};
    end
    if (st3) begin
      angle = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && snap.valid) begin
      lt1 <= snap.left_cnt;
      ct1 <= snap.center_cnt;
      rt1 <= snap.right_cnt;
      st1 <= snap.stopped;
    end
    if (rdy2 && v1) begin
      lt2   <= lt1;
      rt2   <= rt1;
      st2   <= st1;
      prod2 <= ct1 * cfg.center_bias;
    end
    if (rdy3 && v2) begin
      lt3   <= lt2;
      rt3   <= rt2;
      st3   <= st2;
      quot3 <= recip_prod[RecipShift +: QuotW];
    end
    if (rdy4 && v3) begin
      steer_angle   <= angle;
      chosen_region <= region;
      left_total    <= lt3;
      center_total  <= ct_sat;
      right_total   <= rt3;
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Region occupancy steering testbench
// Drives pixel and speed items into the block and checks each result item.
// A scoreboard keeps a cycle-free predictor of the block: window counts,
// positions, the biased center total and the steering choice. Register
// settings change only while the block is idle. Random frames under reset
// settings, directed frames and a row past the column limit come first.
// Random frames follow under random settings, with random gaps on both
// sides, one long output stall and a quiet tail.
// ----------------------------------------------------------------------------

module tb_top;
  import rocs_pkg::*;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_SPEED = 1'b1;
  localparam int   SETTLE   = 20;
  localparam int   LIMIT    = 500000;

  typedef struct {
    logic        op;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        eol;
    logic        eof;
    logic [15:0] speed;
  } pix_item_t;

  typedef struct packed {
    logic [CntW-1:0] right_total;
    logic [CntW-1:0] center_total;
    logic [CntW-1:0] left_total;
    logic [1:0]      region;
    logic [7:0]      angle;
  } steer_t;

  class steer_scoreboard;
    cfg_t            cfg;
    logic [PosW-1:0] col;
    logic [PosW-1:0] row;
    logic [CntW-1:0] left_cnt;
    logic [CntW-1:0] center_cnt;
    logic [CntW-1:0] right_cnt;
    logic            stopped;
    steer_t          steer_due[$];
    int              errors;
    int              items_taken;
    int              steer_checked;

    function new();
      cfg = '{left_width: 10'd213, center_start: 10'd213, center_width: 10'd214,
              right_start: 10'd417, right_width: 10'd213, window_height: 10'd480,
              center_bias: 10'd900, turn_angle: 7'd10};
      col = '0;
      row = '0;
      left_cnt = '0;
      center_cnt = '0;
      right_cnt = '0;
      stopped = 1'b1;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_LEFT_WIDTH:    cfg.left_width    = v[RegW-1:0];
        REG_CENTER_START:  cfg.center_start  = v[RegW-1:0];
        REG_CENTER_WIDTH:  cfg.center_width  = v[RegW-1:0];
        REG_RIGHT_START:   cfg.right_start   = v[RegW-1:0];
        REG_RIGHT_WIDTH:   cfg.right_width   = v[RegW-1:0];
        REG_WINDOW_HEIGHT: cfg.window_height = v[RegW-1:0];
        REG_CENTER_BIAS:   cfg.center_bias   = v[RegW-1:0];
        REG_TURN_ANGLE:    cfg.turn_angle    = v[AngW-1:0];
        default: ;
      endcase
    endfunction

    function bit covers(logic [PosW-1:0] c, logic [RegW-1:0] start, logic [RegW-1:0] width);
      return (c >= start) && ({1'b0, c} < ({1'b0, start} + {1'b0, width}));
    endfunction

    function logic [CntW-1:0] bump(logic [CntW-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function void take_item(pix_item_t it);
      steer_t      res;
      logic [39:0] scaled;
      bit          occupied;
      items_taken++;
      if (it.op == OP_SPEED) begin
        stopped = (it.speed == 16'd0);
        return;
      end
      occupied = !((it.green == 8'd0) && (it.red == 8'd0) &&
                   ((it.blue == 8'd0) || (it.blue == 8'hFF)));
      if (occupied && (row < cfg.window_height)) begin
        if (covers(col, '0, cfg.left_width)) left_cnt = bump(left_cnt);
        if (covers(col, cfg.center_start, cfg.center_width)) center_cnt = bump(center_cnt);
        if (covers(col, cfg.right_start, cfg.right_width)) right_cnt = bump(right_cnt);
      end
      if (it.eol) begin
        col = '0;
        if (row != POS_MAX) row = row + 1'b1;
      end else if (col != POS_MAX) begin
        col = col + 1'b1;
      end
      if (!it.eof) return;
      scaled = (40'(center_cnt) * 40'(cfg.center_bias)) / 40'd1000;
      res.left_total   = left_cnt;
      res.right_total  = right_cnt;
      res.center_total = (scaled > 40'(CNT_MAX)) ? CNT_MAX : scaled[CntW-1:0];
      if ((res.left_total <= res.center_total) && (res.left_total <= res.right_total)) begin
        res.region = REGION_LEFT;
        res.angle  = 8'd0 - {1'b0, cfg.turn_angle};
      end else if (res.center_total <= res.right_total) begin
        res.region = REGION_CENTER;
        res.angle  = 8'd0;
      end else begin
        res.region = REGION_RIGHT;
        res.angle  = {1'b0, cfg.turn_angle};
      end
      if (stopped) res.angle = 8'd0;
      steer_due.push_back(res);
      left_cnt = '0;
      center_cnt = '0;
      right_cnt = '0;
      col = '0;
      row = '0;
    endfunction

    task report(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      errors++;
    endtask

    task check_steer(logic [71:0] data);
      steer_t got;
      steer_t want;
      got = data[69:0];
      if (steer_due.size() == 0) begin
        report($sformatf("result %h with nothing expected", data));
        return;
      end
      want = steer_due.pop_front();
      steer_checked++;
      if (got.angle !== want.angle)
        report($sformatf("frame %0d steer_angle %h, expected %h",
                         steer_checked, got.angle, want.angle));
      if (got.region !== want.region)
        report($sformatf("frame %0d chosen_region %0d, expected %0d",
                         steer_checked, got.region, want.region));
      if (got.left_total !== want.left_total)
        report($sformatf("frame %0d left_total %0d, expected %0d",
                         steer_checked, got.left_total, want.left_total));
      if (got.center_total !== want.center_total)
        report($sformatf("frame %0d center_total %0d, expected %0d",
                         steer_checked, got.center_total, want.center_total));
      if (got.right_total !== want.right_total)
        report($sformatf("frame %0d right_total %0d, expected %0d",
                         steer_checked, got.right_total, want.right_total));
    endtask
  endclass

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [ApbAddrW-1:0] paddr    = '0;
  logic [31:0]         pwdata   = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // blue [7:0], green [15:8], red [23:16], speed_value [39:24]
  logic [39:0]         s_tdata  = '0;
  // op [0], end_of_line [1]
  logic [1:0]          s_tuser  = '0;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // steer_angle [7:0], chosen_region [9:8], left_total [29:10],
  // center_total [49:30], right_total [69:50], zero [71:70]
  logic [71:0]         m_tdata;

  steer_scoreboard sb;
  bit quiet       = 1'b0;
  int idle_odds   = 0;
  int stall_odds  = 0;
  int speed_odds  = 3;
  int hold_cycles = 0;
  int stall_left  = 0;
  int settings_loaded = 0;
  int cycles      = 0;

  always #4 clk = ~clk;

  region_occupancy_steering_top u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  function automatic pix_item_t mk_pix(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                       logic eol, logic eof);
    pix_item_t it;
    it.op    = OP_PIXEL;
    it.blue  = b;
    it.green = g;
    it.red   = r;
    it.eol   = eol;
    it.eof   = eof;
    it.speed = 16'($urandom);
    return it;
  endfunction

  function automatic pix_item_t mk_speed(logic [15:0] v);
    pix_item_t it;
    it = mk_pix(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    it.op    = OP_SPEED;
    it.speed = v;
    return it;
  endfunction

  function automatic pix_item_t random_speed();
    return mk_speed(($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom));
  endfunction

  function automatic pix_item_t random_pixel();
    int k;
    k = $urandom_range(0, 7);
    case ($urandom_range(0, 9))
      0, 1: return mk_pix(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
      2:    return mk_pix(8'hFF, 8'd0, 8'd0, 1'b0, 1'b0);
      3: begin
        case ($urandom_range(0, 2))
          0:       return mk_pix(8'hFF ^ (8'd1 << k), 8'd0, 8'd0, 1'b0, 1'b0);
          1:       return mk_pix(8'hFF, 8'd1 << k, 8'd0, 1'b0, 1'b0);
          default: return mk_pix(8'hFF, 8'd0, 8'd1 << k, 1'b0, 1'b0);
        endcase
      end
      default: return mk_pix(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0);
    endcase
  endfunction

  function automatic cfg_t make_cfg(logic [9:0] lw, logic [9:0] cs, logic [9:0] cw,
                                    logic [9:0] rs, logic [9:0] rw, logic [9:0] h,
                                    logic [9:0] bias, logic [6:0] ang);
    return '{left_width: lw, center_start: cs, center_width: cw, right_start: rs,
             right_width: rw, window_height: h, center_bias: bias, turn_angle: ang};
  endfunction

  function automatic logic [9:0] pick_reg(int hi);
    case ($urandom_range(0, 7))
      0:       return 10'd0;
      1:       return 10'd1023;
      default: return 10'($urandom_range(0, hi));
    endcase
  endfunction

  task automatic apb_write(logic [2:0] idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, v);
  endtask

  task automatic load_settings(cfg_t c);
    apb_write(REG_LEFT_WIDTH,    32'(c.left_width));
    apb_write(REG_CENTER_START,  32'(c.center_start));
    apb_write(REG_CENTER_WIDTH,  32'(c.center_width));
    apb_write(REG_RIGHT_START,   32'(c.right_start));
    apb_write(REG_RIGHT_WIDTH,   32'(c.right_width));
    apb_write(REG_WINDOW_HEIGHT, 32'(c.window_height));
    apb_write(REG_CENTER_BIAS,   32'(c.center_bias));
    apb_write(REG_TURN_ANGLE,    32'(c.turn_angle));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    settings_loaded++;
  endtask

  task automatic send_item(pix_item_t it);
    if (!quiet && ($urandom_range(1, 100) <= idle_odds)) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tdata  <= {it.speed, it.red, it.green, it.blue};
    s_tuser  <= {it.eol, it.op};
    s_tlast  <= it.eof;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.take_item(it);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.steer_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_frame(int cols, int rows, bit ragged);
    int        len;
    pix_item_t it;
    for (int r = 0; r < rows; r++) begin
      len = ragged ? $urandom_range(1, cols) : cols;
      for (int c = 0; c < len; c++) begin
        if ($urandom_range(1, 100) <= speed_odds) send_item(random_speed());
        it = random_pixel();
        it.eol = (c == len - 1);
        it.eof = (r == rows - 1) && (c == len - 1);
        if (it.eof && ragged && ($urandom_range(0, 1) == 1)) it.eol = 1'b0;
        send_item(it);
      end
    end
  endtask

  task automatic random_frames(int count);
    int start;
    start = sb.items_taken;
    while (sb.items_taken - start < count)
      send_frame($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.",
             cycles, sb.steer_due.size());
    $display("** region_occupancy_steering_top: FAILED **");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (m_tvalid === 1'b1 && m_tready) sb.check_steer(m_tdata);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!quiet && ($urandom_range(1, 100) <= stall_odds)) begin
        stall_left = $urandom_range(1, 10) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int rand_start;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings; the block starts out stopped.
    random_frames(20);
    wait_drained();

    // Small windows with the largest angle and a unit bias.
    load_settings(make_cfg(10'd3, 10'd2, 10'd4, 10'd5, 10'd3, 10'd4, 10'd1000, 7'd127));
    send_item(mk_pix(8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    send_item(mk_pix(8'hFF, 8'h00, 8'h00, 1'b0, 1'b0));
    send_item(mk_pix(8'hFF, 8'h00, 8'h01, 1'b0, 1'b0));
    send_item(mk_pix(8'hFF, 8'h01, 8'h00, 1'b1, 1'b0));
    send_item(mk_pix(8'hFE, 8'h00, 8'h00, 1'b0, 1'b0));
    send_item(mk_pix(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0));
    send_item(mk_pix(8'h00, 8'h00, 8'hFF, 1'b1, 1'b0));
    send_item(mk_pix(8'h00, 8'h80, 8'h00, 1'b0, 1'b1));
    send_item(mk_speed(16'h8000));
    send_item(mk_pix(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    for (int c = 0; c < 8; c++)
      send_item(mk_pix(8'hFF, 8'hFF, 8'hFF, 1'b0, c == 7));
    send_item(mk_speed(16'h7FFF));
    for (int c = 0; c < 3; c++)
      send_item(mk_pix(8'h01, 8'h00, 8'h00, 1'b0, c == 2));
    send_item(mk_speed(16'h0000));
    send_item(mk_pix(8'h7F, 8'h7F, 8'h7F, 1'b1, 1'b1));
    send_item(mk_speed(16'hFFFF));
    wait_drained();

    load_settings(make_cfg(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 7'd0));
    random_frames(20);
    wait_drained();
    load_settings(make_cfg(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                           10'd1023, 7'd127));
    random_frames(20);
    wait_drained();

    // A row longer than the column counter can hold.
    load_settings(make_cfg(10'd1023, 10'd1023, 10'd1023, 10'd1020, 10'd1023, 10'd1023,
                           10'd1023, 7'd127));
    speed_odds = 0;
    send_frame(1030, 1, 1'b0);
    wait_drained();
    speed_odds = 3;

    rand_start = sb.items_taken;
    while (sb.items_taken - rand_start < 150) begin
      load_settings(make_cfg(pick_reg(12), pick_reg(12), pick_reg(12), pick_reg(12),
                             pick_reg(12), pick_reg(10), 10'($urandom_range(0, 1023)),
                             7'($urandom_range(0, 127))));
      case ($urandom_range(0, 2))
        0:       idle_odds = 0;
        1:       idle_odds = 10;
        default: idle_odds = 30;
      endcase
      stall_odds = 5 * $urandom_range(0, 6);
      random_frames(50);
      wait_drained();
    end

    // Output held off while single-pixel frames keep coming.
    idle_odds = 0;
    hold_cycles = 300;
    for (int f = 0; f < 60; f++)
      send_item(mk_pix(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'b1));
    wait_drained();

    quiet = 1'b1;
    load_settings(make_cfg(pick_reg(12), pick_reg(12), pick_reg(12), pick_reg(12),
                           pick_reg(12), pick_reg(10), 10'($urandom_range(0, 1023)),
                           7'($urandom_range(0, 127))));
    random_frames(60);
    wait_drained();

    $display("Run covered %0d items and %0d frame results under %0d register settings,",
             sb.items_taken, sb.steer_checked, settings_loaded);
    $display("including a row past the column limit and a long output stall.");
    if (sb.errors == 0) begin
      $display("** region_occupancy_steering_top: PASSED **");
    end else begin
      $display("%0d mismatches found.", sb.errors);
      $display("** region_occupancy_steering_top: FAILED **");
    end
    $finish;
  end

endmodule
